[hw/rtl/pulse_train_transmitter_macros.svh]
`ifndef PULSE_TRAIN_TRANSMITTER_MACROS_SVH
`define PULSE_TRAIN_TRANSMITTER_MACROS_SVH

// Concurrent assertion on clk, switched off while rst_n is low.
`define PTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Cause in one cycle, effect in the next one.
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    `PTT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[hw/rtl/ptt_pkg.sv]
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned DUR_W       = 15;
    localparam int unsigned HALF_W      = 16;
    localparam int unsigned DIV_W       = 8;
    localparam int unsigned MODE_W      = 3;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE     = 3'd0,
        MODE_START     = 3'd1,
        MODE_TICK      = 3'd2,
        MODE_CLEAR_END = 3'd3,
        MODE_RESET_WP  = 3'd4
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CLOCK_DIVIDER   = 2'd0,
        CFG_IDLE_OUT_ENABLE = 2'd1,
        CFG_IDLE_LEVEL      = 2'd2
    } cfg_index_t;

    localparam logic [DIV_W-1:0] DIVIDER_RESET = 8'd1;

endpackage

[hw/rtl/pulse_train_transmitter.sv]
`timescale 1ns / 1ps

// Pulse-train transmitter.
// Input channel (in_valid/in_ready, mode, item_word): one command per transaction:
// write an item word, start, source tick, clear the end flag, or rewind the write pointer.
// Output channel (out_valid/out_ready): one result per command, carrying the pin level,
// the sticky end flag, busy, and whether that command's item write was dropped.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready. The
// user must write it only while the block is idle; the block does not enforce this.
// The result of an accepted command is registered and valid in the cycle after it is accepted.
// Throughput is one command per cycle while results are taken; the result registers
// double as the block state, and the item memory has one registered read port that
// prefetches the next word while the current word plays out of a local register.
// When the receiver stalls, in_ready drops until the pending result is taken.
// Reset clears all control state and loads the configuration defaults; the item memory
// is not cleared and needs no clearing pass.
module pulse_train_transmitter
    import ptt_pkg::*;
#(
    parameter int unsigned MEMORY_WORDS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [MODE_W-1:0]      mode,
    input  logic [WORD_W-1:0]      item_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   pin_level,
    output logic                   tx_end,
    output logic                   busy_res,
    output logic                   write_overflow,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned AW = $clog2(MEMORY_WORDS);
    localparam int unsigned PW = $clog2(MEMORY_WORDS + 1);
    localparam logic [PW-1:0] WORDS_P = PW'(MEMORY_WORDS);
    localparam logic [PW-1:0] LAST_P  = PW'(MEMORY_WORDS - 1);

    logic              out_valid_reg, out_valid_next;
    logic [PW-1:0]     wp_reg, wp_next;
    logic [PW-1:0]     rp_reg, rp_next;
    logic              second_half_reg, second_half_next;
    logic [DIV_W-1:0]  prescale_reg, prescale_next;
    logic [DUR_W-1:0]  duration_reg, duration_next;
    logic              running_reg, running_next;
    logic              end_flag_reg, end_flag_next;
    logic              level_reg, level_next;
    logic              ovf_reg, ovf_next;
    logic [WORD_W-1:0] cur_word_reg, cur_word_next;
    logic [WORD_W-1:0] word0_reg, word0_next;
    logic [DIV_W-1:0]  divider_reg;
    logic              idle_en_reg;
    logic              idle_level_reg;

    logic              in_accept;
    logic [DIV_W-1:0]  div_eff;
    logic [DIV_W-1:0]  prescale_inc;
    logic [DUR_W-1:0]  duration_inc;
    logic [DUR_W-1:0]  cur_dur;
    logic              enter_req;
    logic [HALF_W-1:0] enter_half;
    logic              finish_req;

    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

    assign pin_level      = level_reg;
    assign tx_end         = end_flag_reg;
    assign busy_res       = running_reg;
    assign write_overflow = ovf_reg;

    assign div_eff      = (divider_reg == '0) ? DIVIDER_RESET : divider_reg;
    assign prescale_inc = prescale_reg + DIV_W'(1);
    assign duration_inc = duration_reg + DUR_W'(1);
    assign cur_dur      = second_half_reg ? cur_word_reg[HALF_W+DUR_W-1:HALF_W]
                                          : cur_word_reg[DUR_W-1:0];

    // Writes are dropped while running, so the memory is never read and written in the
    // same transmission. The word after the current one is prefetched on start and on
    // every advance to a word before the last; at least two ticks pass before it is needed.
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        second_half_next = second_half_reg;
        prescale_next    = prescale_reg;
        duration_next    = duration_reg;
        running_next     = running_reg;
        end_flag_next    = end_flag_reg;
        level_next       = level_reg;
        ovf_next         = ovf_reg;
        cur_word_next    = cur_word_reg;
        word0_next       = word0_reg;
        enter_req        = 1'b0;
        enter_half       = '0;
        finish_req       = 1'b0;
        ram_wr_en        = 1'b0;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = '0;

        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_accept)
        begin
            ovf_next = 1'b0;
            unique case (mode)
                MODE_WRITE:
                begin
                    if (running_reg || wp_reg >= WORDS_P)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ram_wr_en = 1'b1;
                        wp_next   = wp_reg + PW'(1);
                        if (wp_reg == '0)
                        begin
                            word0_next = item_word;
                        end
                    end
                end
                MODE_START:
                begin
                    rp_next          = '0;
                    second_half_next = 1'b0;
                    prescale_next    = '0;
                    running_next     = 1'b1;
                    cur_word_next    = word0_reg;
                    enter_req        = 1'b1;
                    enter_half       = word0_reg[HALF_W-1:0];
                    ram_rd_en        = 1'b1;
                    ram_rd_addr      = AW'(1);
                end
                MODE_TICK:
                begin
                    if (running_reg)
                    begin
                        if (prescale_inc < div_eff)
                        begin
                            prescale_next = prescale_inc;
                        end
                        else
                        begin
                            prescale_next = '0;
                            duration_next = duration_inc;
                            if (duration_inc >= cur_dur)
                            begin
                                if (!second_half_reg)
                                begin
                                    second_half_next = 1'b1;
                                    enter_req        = 1'b1;
                                    enter_half       = cur_word_reg[WORD_W-1:HALF_W];
                                end
                                else
                                begin
                                    second_half_next = 1'b0;
                                    rp_next          = rp_reg + PW'(1);
                                    if (rp_next >= WORDS_P)
                                    begin
                                        finish_req = 1'b1;
                                    end
                                    else
                                    begin
                                        cur_word_next = ram_rd_data;
                                        enter_req     = 1'b1;
                                        enter_half    = ram_rd_data[HALF_W-1:0];
                                        if (rp_next < LAST_P)
                                        begin
                                            ram_rd_en   = 1'b1;
                                            ram_rd_addr = AW'(rp_next + PW'(1));
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                MODE_CLEAR_END:
                begin
                    end_flag_next = 1'b0;
                end
                MODE_RESET_WP:
                begin
                    wp_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (enter_req)
        begin
            if (enter_half[DUR_W-1:0] == '0)
            begin
                finish_req = 1'b1;
            end
            else
            begin
                level_next    = enter_half[HALF_W-1];
                duration_next = '0;
            end
        end

        if (finish_req)
        begin
            running_next  = 1'b0;
            end_flag_next = 1'b1;
            prescale_next = '0;
            duration_next = '0;
            if (idle_en_reg)
            begin
                level_next = idle_level_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            wp_reg          <= '0;
            rp_reg          <= '0;
            second_half_reg <= 1'b0;
            prescale_reg    <= '0;
            duration_reg    <= '0;
            running_reg     <= 1'b0;
            end_flag_reg    <= 1'b0;
            level_reg       <= 1'b0;
            ovf_reg         <= 1'b0;
            divider_reg     <= DIVIDER_RESET;
            idle_en_reg     <= 1'b1;
            idle_level_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            wp_reg          <= wp_next;
            rp_reg          <= rp_next;
            second_half_reg <= second_half_next;
            prescale_reg    <= prescale_next;
            duration_reg    <= duration_next;
            running_reg     <= running_next;
            end_flag_reg    <= end_flag_next;
            level_reg       <= level_next;
            ovf_reg         <= ovf_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_CLOCK_DIVIDER:   divider_reg    <= cfg_data;
                    CFG_IDLE_OUT_ENABLE: idle_en_reg    <= cfg_data[0];
                    CFG_IDLE_LEVEL:      idle_level_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_word_reg <= cur_word_next;
        word0_reg    <= word0_next;
    end

    ptt_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MEMORY_WORDS)
    ) u_item_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(wp_reg[AW-1:0]),
        .wr_data(item_word),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

endmodule

[hw/rtl/ptt_ram.sv]
`timescale 1ns / 1ps

module ptt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/ptt_checker.sv]
`timescale 1ns / 1ps

`include "pulse_train_transmitter_macros.svh"

module ptt_checker
    import ptt_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [MODE_W-1:0]      mode,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   pin_level,
    input logic                   tx_end,
    input logic                   busy_res,
    input logic                   write_overflow
);

    `PTT_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "accepted transaction gave no result")
    `PTT_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(pin_level) && $stable(tx_end) && $stable(busy_res) && $stable(write_overflow), "stalled result changed")
    `PTT_ASSERT_NEXT(a_overflow_only_write, in_valid && in_ready && mode != MODE_WRITE, !write_overflow, "overflow flagged on a non-write transaction")
    `PTT_ASSERT_NEXT(a_clear_end, in_valid && in_ready && mode == MODE_CLEAR_END, !tx_end, "end flag not cleared")
    `PTT_ASSERT_NEXT(a_busy_needs_start, in_valid && in_ready && !busy_res && mode != MODE_START, !busy_res, "busy rose without a start")

endmodule

bind pulse_train_transmitter ptt_checker u_ptt_checker (.*);
